[design/tptf_pkg.sv]
// Package for the address translation core: field widths, table sizes,
// status codes and the control structs passed between the submodules.
// No dependencies.
package tptf_pkg;

   localparam int VA_W        = 16;
   localparam int PA_W        = 15;
   localparam int FRAME_OUT_W = 7;
   localparam int STATUS_W    = 2;

   localparam int PAGE_COUNT  = 256;
   localparam int FRAME_BYTES = 256;
   localparam int OFFSET_W    = $clog2(FRAME_BYTES);
   localparam int PAGE_W      = $clog2(PAGE_COUNT);

   localparam int FRAME_COUNT_DEF = 128;
   localparam int TLB_ENTRIES_DEF = 16;

   localparam logic [STATUS_W-1:0] ST_TLB_HIT = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PT_HIT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FAULT   = 2'd2;

   typedef struct packed {
      logic fill_en;
      logic evict_en;
      logic advance_en;
   } tlb_ctl_type;

   typedef struct packed {
      logic read_en;
      logic map_en;
   } pt_ctl_type;

endpackage

[design/tptf_tlb.sv]
// Fully associative TLB: tag, frame and valid registers, parallel lookup,
// victim invalidation and round-robin refill.
// Depends on tptf_pkg.
module tptf_tlb #(
   parameter int TLB_ENTRIES = tptf_pkg::TLB_ENTRIES_DEF,
   parameter int FRAME_COUNT = tptf_pkg::FRAME_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [tptf_pkg::PAGE_W-1:0]          page,
   input  tptf_pkg::tlb_ctl_type                ctl,
   input  logic [$clog2(FRAME_COUNT)-1:0]       fill_frame,
   input  logic [tptf_pkg::PAGE_W-1:0]          evict_page,
   output logic                                 hit,
   output logic [$clog2(FRAME_COUNT)-1:0]       hit_frame
);
   import tptf_pkg::*;

   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam int PTR_W   = $clog2(TLB_ENTRIES);

   logic [PAGE_W-1:0]      tag_ff   [TLB_ENTRIES];
   logic [FRAME_W-1:0]     frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] valid_ff, valid_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;

   // lowest matching index wins: scan downward so the last match sticks
   always_comb begin
      hit       = 1'b0;
      hit_frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == page) begin
            hit       = 1'b1;
            hit_frame = frame_ff[i];
         end
      end
   end

   // drop entries of the evicted page, then refill at the pointer
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (ctl.evict_en && valid_ff[i] && tag_ff[i] == evict_page) begin
            valid_in[i] = 1'b0;
         end
      end
      if (ctl.fill_en) begin
         valid_in[ptr_ff] = 1'b1;
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (ctl.advance_en) begin
         ptr_in = (ptr_ff == PTR_W'(TLB_ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fill_en) begin
         tag_ff[ptr_ff]   <= page;
         frame_ff[ptr_ff] <= fill_frame;
      end
   end

endmodule

[design/tptf_page_table.sv]
// Page table: frame memory, present bits, frame owner memory and the FIFO
// frame counter with its wrap flag.
// Depends on tptf_pkg.
module tptf_page_table #(
   parameter int FRAME_COUNT = tptf_pkg::FRAME_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tptf_pkg::pt_ctl_type                 ctl,
   input  logic [tptf_pkg::PAGE_W-1:0]          rd_page,
   input  logic [tptf_pkg::PAGE_W-1:0]          page,
   output logic                                 present,
   output logic [$clog2(FRAME_COUNT)-1:0]       pt_frame,
   output logic [$clog2(FRAME_COUNT)-1:0]       next_frame,
   output logic                                 memory_full,
   output logic [tptf_pkg::PAGE_W-1:0]          owner_page
);
   import tptf_pkg::*;

   localparam int FRAME_W = $clog2(FRAME_COUNT);

   logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
   logic [PAGE_W-1:0]     owner_mem [FRAME_COUNT];
   logic [PAGE_COUNT-1:0] present_ff, present_in;
   logic [FRAME_W-1:0]    next_frame_ff, next_frame_in;
   logic                  full_ff, full_in;
   logic [FRAME_W-1:0]    pt_frame_ff;
   logic [PAGE_W-1:0]     owner_ff;

   assign present     = present_ff[page];
   assign pt_frame    = pt_frame_ff;
   assign next_frame  = next_frame_ff;
   assign memory_full = full_ff;
   assign owner_page  = owner_ff;

   always_comb begin
      present_in    = present_ff;
      next_frame_in = next_frame_ff;
      full_in       = full_ff;
      if (ctl.map_en) begin
         if (full_ff) begin
            present_in[owner_ff] = 1'b0;
         end
         present_in[page] = 1'b1;
         if (next_frame_ff == FRAME_W'(FRAME_COUNT - 1)) begin
            next_frame_in = '0;
            full_in       = 1'b1;
         end else begin
            next_frame_in = next_frame_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         next_frame_ff <= '0;
         full_ff       <= 1'b0;
      end else begin
         present_ff    <= present_in;
         next_frame_ff <= next_frame_in;
         full_ff       <= full_in;
      end
   end

   // reads are taken at input transfer and held until the next one
   always_ff @(posedge clock) begin
      if (ctl.read_en) begin
         pt_frame_ff <= frame_mem[rd_page];
         owner_ff    <= owner_mem[next_frame_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.map_en) begin
         frame_mem[page]          <= next_frame_ff;
         owner_mem[next_frame_ff] <= page;
      end
   end

endmodule

[design/tlb_page_table_translate_fifo_core.sv]
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   virtual_address
// rsp       out        rsp_valid/rsp_ready   physical_address, frame_number, status,
//                                            evicted_valid, evicted_page
// For each item the transfer edge starts the page-table and frame-owner memory reads;
// the commit edge in lookup, taken once the result register is free, resolves the TLB
// and page table, writes back and loads the result register.
// Reset is synchronous and clears present bits, TLB valid bits and the counters.
// A stalled result holds the block in lookup until the result register frees.
module tlb_page_table_translate_fifo_core #(
   parameter int TLB_ENTRIES = tptf_pkg::TLB_ENTRIES_DEF,
   parameter int FRAME_COUNT = tptf_pkg::FRAME_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tptf_pkg::VA_W-1:0]            req_virtual_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tptf_pkg::PA_W-1:0]            rsp_physical_address,
   output logic [tptf_pkg::FRAME_OUT_W-1:0]     rsp_frame_number,
   output logic [tptf_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_evicted_valid,
   output logic [tptf_pkg::PAGE_W-1:0]          rsp_evicted_page
);
   import tptf_pkg::*;

   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam logic S_IDLE   = 1'b0;
   localparam logic S_LOOKUP = 1'b1;

   logic                state_ff, state_in;
   logic [PAGE_W-1:0]   page_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic                accept, out_free, commit;

   logic                tlb_hit;
   logic [FRAME_W-1:0]  tlb_frame;
   logic                present;
   logic [FRAME_W-1:0]  pt_frame;
   logic [FRAME_W-1:0]  next_frame;
   logic                memory_full;
   logic [PAGE_W-1:0]   owner_page;

   tlb_ctl_type         tlb_ctl;
   pt_ctl_type          pt_ctl;

   logic [STATUS_W-1:0]            status_c;
   logic [FRAME_W-1:0]             frame_c;
   logic [FRAME_W+FRAME_OUT_W-1:0] frame_wide;
   logic [FRAME_OUT_W-1:0]         frame_out;
   logic                           ev_valid_c;
   logic [PAGE_W-1:0]              ev_page_c;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]        pa_ff;
   logic [FRAME_OUT_W-1:0] frame_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic                   ev_valid_ff;
   logic [PAGE_W-1:0]      ev_page_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == S_LOOKUP) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) state_in = S_LOOKUP;
         S_LOOKUP: if (commit) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff   <= req_virtual_address[OFFSET_W+PAGE_W-1:OFFSET_W];
         offset_ff <= req_virtual_address[OFFSET_W-1:0];
      end
   end

   // resolve TLB hit, page-table hit or fault
   always_comb begin
      ev_valid_c = 1'b0;
      ev_page_c  = '0;
      if (tlb_hit) begin
         status_c = ST_TLB_HIT;
         frame_c  = tlb_frame;
      end else if (present) begin
         status_c = ST_PT_HIT;
         frame_c  = pt_frame;
      end else begin
         status_c   = ST_FAULT;
         frame_c    = next_frame;
         ev_valid_c = memory_full;
         ev_page_c  = memory_full ? owner_page : '0;
      end
   end

   assign frame_wide = {{FRAME_OUT_W{1'b0}}, frame_c};
   assign frame_out  = frame_wide[FRAME_OUT_W-1:0];

   always_comb begin
      tlb_ctl.fill_en    = commit && (status_c != ST_TLB_HIT);
      tlb_ctl.evict_en   = commit && (status_c == ST_FAULT) && memory_full;
      tlb_ctl.advance_en = commit && (status_c == ST_FAULT);
      pt_ctl.read_en     = accept;
      pt_ctl.map_en      = commit && (status_c == ST_FAULT);
   end

   tptf_tlb #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .FRAME_COUNT (FRAME_COUNT)
   ) u_tlb (
      .clock      (clock),
      .reset      (reset),
      .page       (page_ff),
      .ctl        (tlb_ctl),
      .fill_frame (frame_c),
      .evict_page (owner_page),
      .hit        (tlb_hit),
      .hit_frame  (tlb_frame)
   );

   tptf_page_table #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_page_table (
      .clock       (clock),
      .reset       (reset),
      .ctl         (pt_ctl),
      .rd_page     (req_virtual_address[OFFSET_W+PAGE_W-1:OFFSET_W]),
      .page        (page_ff),
      .present     (present),
      .pt_frame    (pt_frame),
      .next_frame  (next_frame),
      .memory_full (memory_full),
      .owner_page  (owner_page)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         pa_ff       <= {frame_out[PA_W-OFFSET_W-1:0], offset_ff};
         frame_ff    <= frame_out;
         status_ff   <= status_c;
         ev_valid_ff <= ev_valid_c;
         ev_page_ff  <= ev_page_c;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = pa_ff;
   assign rsp_frame_number     = frame_ff;
   assign rsp_status           = status_ff;
   assign rsp_evicted_valid    = ev_valid_ff;
   assign rsp_evicted_page     = ev_page_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !commit)
      else $error("result register overwritten while held");

   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP) |-> !req_ready)
      else $error("input taken during lookup");

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOKUP))
      else $error("transfer did not start a lookup");

   a_refill_hits: assert property (@(posedge clock) disable iff (reset)
      (commit && status_c != ST_TLB_HIT) |=> tlb_hit)
      else $error("refilled page misses in the TLB");

   a_evict_only_on_fault: assert property (@(posedge clock) disable iff (reset)
      (commit && status_c != ST_FAULT) |-> !ev_valid_c)
      else $error("eviction reported without a fault");

endmodule

[bench/tlb_page_table_translate_fifo_core_tb.sv]
// Testbench for tlb_page_table_translate_fifo_core: drives virtual addresses, predicts each
// translation with a behavioral TLB/page-table model and checks every response in order.
// Depends on tptf_pkg and the core RTL only.
`timescale 1ns / 100ps

module tlb_page_table_translate_fifo_core_tb;
   import tptf_pkg::*;

   localparam int FRAMES      = FRAME_COUNT_DEF;
   localparam int TLB_SLOTS   = TLB_ENTRIES_DEF;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [PA_W-1:0]        phys;
      logic [FRAME_OUT_W-1:0] frame;
      logic [STATUS_W-1:0]    status;
      logic                   ev_valid;
      logic [PAGE_W-1:0]      ev_page;
   } translation_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [VA_W-1:0]        req_virtual_address = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PA_W-1:0]        rsp_physical_address;
   logic [FRAME_OUT_W-1:0] rsp_frame_number;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   rsp_evicted_valid;
   logic [PAGE_W-1:0]      rsp_evicted_page;

   // shadow copy of the translation state
   logic [FRAME_OUT_W-1:0] shadow_page_frame [PAGE_COUNT];
   logic                   shadow_present    [PAGE_COUNT];
   logic [PAGE_W-1:0]      shadow_owner      [FRAMES];
   logic [PAGE_W-1:0]      shadow_tlb_tag    [TLB_SLOTS];
   logic [FRAME_OUT_W-1:0] shadow_tlb_frame  [TLB_SLOTS];
   logic                   shadow_tlb_valid  [TLB_SLOTS];
   int                     shadow_tlb_ptr;
   int                     shadow_next_frame;
   logic                   shadow_mem_full;

   translation_type pending_translations[$];
   int              error_count = 0;
   int              idle_cycles = 0;
   logic            stall_enable = 1'b1;

   tlb_page_table_translate_fifo_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_physical_address (rsp_physical_address),
      .rsp_frame_number     (rsp_frame_number),
      .rsp_status           (rsp_status),
      .rsp_evicted_valid    (rsp_evicted_valid),
      .rsp_evicted_page     (rsp_evicted_page)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic translation_type translate_address(input logic [VA_W-1:0] va);
      translation_type        r;
      logic [PAGE_W-1:0]      page;
      logic [OFFSET_W-1:0]    offset;
      logic [PAGE_W-1:0]      victim;
      logic [FRAME_OUT_W-1:0] frame;
      logic [31:0]            addr;
      int                     hit;
      r      = '0;
      page   = va[OFFSET_W +: PAGE_W];
      offset = va[OFFSET_W-1:0];
      frame  = '0;
      hit    = -1;
      for (int i = 0; i < TLB_SLOTS; i++) begin
         if (hit < 0 && shadow_tlb_valid[i] && shadow_tlb_tag[i] == page) hit = i;
      end
      if (hit >= 0) begin
         frame    = shadow_tlb_frame[hit];
         r.status = ST_TLB_HIT;
      end else if (shadow_present[page]) begin
         // refill at the pointer, hold the pointer
         frame = shadow_page_frame[page];
         shadow_tlb_tag[shadow_tlb_ptr]   = page;
         shadow_tlb_frame[shadow_tlb_ptr] = frame;
         shadow_tlb_valid[shadow_tlb_ptr] = 1'b1;
         r.status = ST_PT_HIT;
      end else begin
         frame = FRAME_OUT_W'(shadow_next_frame);
         if (shadow_mem_full) begin
            // drop the victim from the page table and the TLB
            victim = shadow_owner[shadow_next_frame];
            shadow_present[victim] = 1'b0;
            for (int i = 0; i < TLB_SLOTS; i++) begin
               if (shadow_tlb_valid[i] && shadow_tlb_tag[i] == victim)
                  shadow_tlb_valid[i] = 1'b0;
            end
            r.ev_valid = 1'b1;
            r.ev_page  = victim;
         end
         shadow_page_frame[page]          = frame;
         shadow_present[page]             = 1'b1;
         shadow_owner[shadow_next_frame]  = page;
         shadow_tlb_tag[shadow_tlb_ptr]   = page;
         shadow_tlb_frame[shadow_tlb_ptr] = frame;
         shadow_tlb_valid[shadow_tlb_ptr] = 1'b1;
         shadow_tlb_ptr = (shadow_tlb_ptr + 1) % TLB_SLOTS;
         shadow_next_frame = shadow_next_frame + 1;
         if (shadow_next_frame >= FRAMES) begin
            shadow_next_frame = 0;
            shadow_mem_full   = 1'b1;
         end
         r.status = ST_FAULT;
      end
      addr    = 32'(frame) * FRAME_BYTES + 32'(offset);
      r.phys  = addr[PA_W-1:0];
      r.frame = frame;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
      error_count++;
   endtask

   // one request transfer; valid stays high into the next call unless an idle gap is taken
   task automatic send_address(input logic [VA_W-1:0] va);
      int gap;
      gap = 0;
      if (stall_enable && $urandom_range(99) < 8) gap = $urandom_range(3, 1);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_virtual_address <= va;
      do @(posedge clock); while (!req_ready);
      pending_translations.push_back(translate_address(va));
   endtask

   task automatic test_directed_extremes();
      send_address(16'h0000);   // first fault after reset takes frame 0
      send_address(16'hFFFF);
      send_address(16'h00FF);   // TLB hits on both ends of the offset
      send_address(16'hFF00);
      send_address(16'h5555);
      send_address(16'hAAAA);
      // sixteen more faults wrap the TLB pointer over the earlier pages
      for (int p = 16; p < 32; p++) send_address({8'(p), 8'(p * 7)});
      // page-table hits refill the same slot, since the pointer holds
      send_address(16'h0001);
      send_address(16'hFF7F);
      send_address(16'h0002);
   endtask

   task automatic test_frame_wrap();
      int perm [PAGE_COUNT];
      int j;
      int t;
      for (int i = 0; i < PAGE_COUNT; i++) perm[i] = i;
      for (int i = PAGE_COUNT - 1; i > 0; i--) begin
         j       = $urandom_range(i);
         t       = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      // long stretch with no idling on either side
      stall_enable = 1'b0;
      for (int i = 0; i < PAGE_COUNT; i++)
         send_address({8'(perm[i]), 8'($urandom_range(255))});
      stall_enable = 1'b1;
   endtask

   task automatic test_working_set();
      logic [PAGE_W-1:0] set_pages [40];
      int                set_size;
      for (int epoch = 0; epoch < 12; epoch++) begin
         set_size = $urandom_range(40, 4);
         for (int i = 0; i < set_size; i++) set_pages[i] = PAGE_W'($urandom_range(255));
         for (int n = 0; n < 50; n++)
            send_address({set_pages[$urandom_range(set_size - 1)], 8'($urandom_range(255))});
      end
   endtask

   task automatic test_random_addresses();
      for (int n = 0; n < 500; n++) send_address(VA_W'($urandom_range(16'hFFFF)));
   endtask

   task automatic test_mixed_locality();
      logic [VA_W-1:0] last_va;
      last_va = '0;
      for (int n = 0; n < 220; n++) begin
         // revisit the last page half the time, otherwise jump anywhere
         if ($urandom_range(1)) last_va = {last_va[15:8], 8'($urandom_range(255))};
         else last_va = VA_W'($urandom_range(16'hFFFF));
         send_address(last_va);
      end
   endtask

   always @(negedge clock) begin
      if (stall_enable) rsp_ready <= ($urandom_range(99) >= 8);
      else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      translation_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_translations.size() == 0) begin
            report_mismatch("unexpected_response", 32'(rsp_physical_address), 32'd0);
         end else begin
            want = pending_translations.pop_front();
            if (rsp_physical_address != want.phys)
               report_mismatch("physical_address", 32'(rsp_physical_address), 32'(want.phys));
            if (rsp_frame_number != want.frame)
               report_mismatch("frame_number", 32'(rsp_frame_number), 32'(want.frame));
            if (rsp_status != want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_evicted_valid != want.ev_valid)
               report_mismatch("evicted_valid", 32'(rsp_evicted_valid), 32'(want.ev_valid));
            if (rsp_evicted_page != want.ev_page)
               report_mismatch("evicted_page", 32'(rsp_evicted_page), 32'(want.ev_page));
         end
      end
   end

   // count cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < PAGE_COUNT; i++) begin
         shadow_page_frame[i] = '0;
         shadow_present[i]    = 1'b0;
      end
      for (int i = 0; i < FRAMES; i++) shadow_owner[i] = '0;
      for (int i = 0; i < TLB_SLOTS; i++) begin
         shadow_tlb_tag[i]   = '0;
         shadow_tlb_frame[i] = '0;
         shadow_tlb_valid[i] = 1'b0;
      end
      shadow_tlb_ptr    = 0;
      shadow_next_frame = 0;
      shadow_mem_full   = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_directed_extremes();
      test_frame_wrap();
      test_working_set();
      test_random_addresses();
      test_mixed_locality();

      @(negedge clock) req_valid <= 1'b0;
      while (pending_translations.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
